>>> hw/rtl/thpb_pkg.sv
// Package with shared constants, codes and helpers for the trend history plot buffer.
package thpb_pkg;

  localparam int HISTORY_DEPTH = 313;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int HIST_CW       = $clog2(HISTORY_DEPTH + 1);

  // Plot geometry.
  localparam int X_OFFSET  = 7;
  localparam int Y_BASE    = 232;
  localparam int Y_CLAMP   = 230;

  // Constant division by multiply and shift, exact for every 16-bit value.
  localparam logic [16:0] RECIP_DIV3  = 17'd43691;
  localparam int          SHIFT_DIV3  = 17;
  localparam logic [16:0] RECIP_DIV10 = 17'd52429;
  localparam int          SHIFT_DIV10 = 19;
  localparam logic [16:0] RECIP_DIV25 = 17'd83887;
  localparam int          SHIFT_DIV25 = 21;

  // Item function codes.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Plot channel codes; the last one has no defined scale.
  localparam logic [1:0] CH_PM   = 2'd0;
  localparam logic [1:0] CH_CO2  = 2'd1;
  localparam logic [1:0] CH_HCHO = 2'd2;
  localparam logic [1:0] CH_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_PLOT_CHANNEL = 2'd0;
  localparam logic [1:0] REG_CO2_RANGE    = 2'd1;

  // Packed history word: one sample triple per entry.
  typedef struct packed {
    logic [15:0] pm;
    logic [15:0] co2;
    logic [15:0] hcho;
  } hist_word_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_FIN  = 3'b100
  } thpb_state_t;

  // Slot of position pos relative to head; both operands are below the depth.
  function automatic logic [HIST_AW-1:0] slot_wrap(input logic [HIST_AW-1:0] head,
                                                   input logic [HIST_AW-1:0] pos);
    logic [HIST_AW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (HIST_AW+1)'(HISTORY_DEPTH)) begin
      sum = sum - (HIST_AW+1)'(HISTORY_DEPTH);
    end
    return sum[HIST_AW-1:0];
  endfunction

endpackage

>>> hw/rtl/trend_history_plot_buffer_top.sv
// Top level of the trend history plot buffer: circular sample store and plot point read.
//
// Usage: items arrive on the in_* channel (valid/ready). A push item (func 0) stores one
// particulate, CO2 and formaldehyde sample triple; a read item (func 1) names a history
// position, 0 being the oldest, and returns the pixel of the channel that plot_channel
// selects. Every item yields exactly one transfer on the out_* channel, which also reports
// the fill count and whether the history is full. Once full, each push overwrites the
// oldest entry and advances the head pointer.
// Timing: a push's result is registered and appears in the cycle after acceptance, and
// pushes can stream one per cycle while the out_* channel does not stall. A read passes
// through the registered history memory read, the multiply with a reciprocal that forms
// the scaled value in ST_MUL, and the clamp and subtraction that load the output register
// in ST_FIN; no further item is taken until the sequencer is back in ST_IDLE.
// Stalls: the output register holds a result until its transfer completes. A read is taken
// while a result still waits; a push, or the end of a read, waits for the register to free.
// Configuration transfers (plot_channel, co2_wide_range) are always taken and are meant
// to happen only while the block is idle.
// Reset: clears the fill count, the head pointer, the configuration and the output valid.
// The history memory itself is not cleared; only written entries are ever read.
module trend_history_plot_buffer_top
  import thpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  // Item channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [15:0] pm_sample,
  input  logic [15:0] co2_sample,
  input  logic [15:0] hcho_sample,
  input  logic [8:0]  point_index,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        point_valid,
  output logic [8:0]  pixel_x,
  output logic [7:0]  pixel_y,
  output logic [8:0]  fill_count,
  output logic        history_full
);

  thpb_state_t        state, state_next;
  logic [1:0]         plot_channel;
  logic               co2_wide_range;
  logic [HIST_AW-1:0] oldest;
  logic [HIST_CW-1:0] count;
  logic               full;

  hist_word_t         hist_mem [HISTORY_DEPTH];
  hist_word_t         rd_word;
  logic [8:0]         rd_idx;
  logic               rd_ok;
  logic [15:0]        quot;

  logic               accept;
  logic               push_go;
  logic               read_go;
  logic               out_free;
  logic               fin_load;
  logic [HIST_AW-1:0] push_slot;
  logic [HIST_AW-1:0] read_slot;
  logic               idx_held;

  logic [15:0]        sel_value;
  logic [32:0]        product;
  logic [15:0]        quot_next;
  logic [15:0]        quot_clamped;

  assign cfg_ready = 1'b1;
  assign full      = (count == HIST_CW'(HISTORY_DEPTH));
  assign out_free  = !out_valid || out_ready;

  // A read can enter while the previous result waits; a push needs the output register.
  assign in_ready = (state == ST_IDLE) && ((func == FUNC_READ) || out_free);
  assign accept   = in_valid && in_ready;
  assign push_go  = accept && (func == FUNC_PUSH);
  assign read_go  = accept && (func == FUNC_READ);
  assign fin_load = (state == ST_FIN) && out_free;

  // While filling, the append slot sits count entries past the head; once full the
  // oldest entry is replaced.
  assign push_slot = full ? oldest : slot_wrap(oldest, HIST_AW'(count));
  assign read_slot = slot_wrap(oldest, HIST_AW'(point_index));
  assign idx_held  = (HIST_CW > 9) ? (HIST_CW'(point_index) < count)
                                   : (point_index < 9'(count));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      plot_channel   <= CH_PM;
      co2_wide_range <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PLOT_CHANNEL: plot_channel   <= cfg_data;
        REG_CO2_RANGE:    co2_wide_range <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Head pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
    end else if (push_go) begin
      if (full) begin
        oldest <= slot_wrap(oldest, HIST_AW'(1));
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // History memory: one write port for pushes, one registered read port for reads.
  always_ff @(posedge clk) begin
    if (push_go) begin
      hist_mem[push_slot] <= '{pm: pm_sample, co2: co2_sample, hcho: hcho_sample};
    end
    if (read_go && idx_held) begin
      rd_word <= hist_mem[read_slot];
    end
  end

  // Read item bookkeeping, held until the result is loaded.
  always_ff @(posedge clk) begin
    if (read_go) begin
      rd_idx <= point_index;
      rd_ok  <= idx_held && (plot_channel != CH_NONE);
    end
  end

  // Channel select and scaling by reciprocal multiply.
  always_comb begin
    case (plot_channel)
      CH_PM: begin
        sel_value = rd_word.pm;
        product   = 33'(sel_value) * 33'(RECIP_DIV3);
        quot_next = 16'(product >> SHIFT_DIV3);
      end
      CH_CO2: begin
        sel_value = rd_word.co2;
        if (co2_wide_range) begin
          product   = 33'(sel_value) * 33'(RECIP_DIV25);
          quot_next = 16'(product >> SHIFT_DIV25);
        end else begin
          product   = 33'(sel_value) * 33'(RECIP_DIV10);
          quot_next = 16'(product >> SHIFT_DIV10);
        end
      end
      CH_HCHO: begin
        sel_value = rd_word.hcho;
        product   = 33'(sel_value) * 33'(RECIP_DIV3);
        quot_next = 16'(product >> SHIFT_DIV3);
      end
      default: begin
        sel_value = '0;
        product   = '0;
        quot_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      quot <= quot_next;
    end
  end

  assign quot_clamped = (quot > 16'(Y_CLAMP)) ? 16'(Y_CLAMP) : quot;

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (read_go) state_next = ST_MUL;
      ST_MUL:  state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_go || fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      point_valid  <= 1'b0;
      pixel_x      <= '0;
      pixel_y      <= '0;
      fill_count   <= full ? 9'(count) : 9'(count + 1'b1);
      history_full <= full || ((count + 1'b1) == HIST_CW'(HISTORY_DEPTH));
    end else if (fin_load) begin
      point_valid  <= rd_ok;
      pixel_x      <= rd_ok ? 9'(rd_idx + 9'(X_OFFSET)) : '0;
      pixel_y      <= rd_ok ? 8'(16'(Y_BASE) - quot_clamped) : '0;
      fill_count   <= 9'(count);
      history_full <= full;
    end
  end

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= HIST_CW'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  a_head_still: assert property (@(posedge clk) disable iff (rst)
    !full |-> oldest == '0)
    else $error("head pointer moved before history was full");

  a_read_seq: assert property (@(posedge clk) disable iff (rst)
    read_go |=> state == ST_MUL ##1 state == ST_FIN)
    else $error("read item left the read sequence");

  a_pixel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && point_valid |-> pixel_y >= 8'd2 && pixel_y <= 8'(Y_BASE))
    else $error("plot row outside the clamped range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !push_go && !fin_load)
    else $error("pending result overwritten");

endmodule

>>> dv/trend_history_plot_buffer_checker.sv
// Checker that predicts every plot buffer result and compares it with the one observed.
`timescale 1ns / 1ps

module trend_history_plot_buffer_checker
  import thpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [15:0] pm_sample,
  input  logic [15:0] co2_sample,
  input  logic [15:0] hcho_sample,
  input  logic [8:0]  point_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        point_valid,
  input  logic [8:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  input  logic [8:0]  fill_count,
  input  logic        history_full,
  output int          error_count,
  output int          pending
);

  localparam int PM_HCHO_DIVISOR   = 3;
  localparam int CO2_NARROW_DIVISOR = 10;
  localparam int CO2_WIDE_DIVISOR   = 25;

  typedef struct packed {
    logic       point_valid;
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic [8:0] fill_count;
    logic       history_full;
  } plot_point_t;

  // Shadow copy of the sample stores, head and fill count.
  logic [15:0] pm_shadow   [HISTORY_DEPTH];
  logic [15:0] co2_shadow  [HISTORY_DEPTH];
  logic [15:0] hcho_shadow [HISTORY_DEPTH];
  int          head_slot;
  int          held_entries;
  logic [1:0]  shadow_channel;
  logic        shadow_wide;

  plot_point_t expected_points[$];
  plot_point_t want;

  task automatic report_mismatch(input string what, input int got, input int wanted);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, wanted);
    error_count++;
  endtask

  function automatic int wrap_slot(input int pos);
    int s;
    s = head_slot + pos;
    if (s >= HISTORY_DEPTH) s -= HISTORY_DEPTH;
    return s;
  endfunction

  // Updates the shadow state for one item and returns the result it must produce.
  function automatic plot_point_t predict_plot_point(input logic f, input logic [15:0] pm,
                                                     input logic [15:0] co2,
                                                     input logic [15:0] hcho,
                                                     input logic [8:0] idx);
    plot_point_t r;
    int slot;
    int value;
    int divisor;
    int quotient;
    r = '0;
    if (f == FUNC_PUSH) begin
      if (held_entries < HISTORY_DEPTH) begin
        slot = wrap_slot(held_entries);
        held_entries++;
      end else begin
        slot = head_slot;
        head_slot = wrap_slot(1);
      end
      pm_shadow[slot]   = pm;
      co2_shadow[slot]  = co2;
      hcho_shadow[slot] = hcho;
    end else if (int'(idx) < held_entries && shadow_channel <= CH_HCHO) begin
      slot = wrap_slot(int'(idx));
      case (shadow_channel)
        CH_PM: begin
          value   = pm_shadow[slot];
          divisor = PM_HCHO_DIVISOR;
        end
        CH_CO2: begin
          value   = co2_shadow[slot];
          divisor = shadow_wide ? CO2_WIDE_DIVISOR : CO2_NARROW_DIVISOR;
        end
        default: begin
          value   = hcho_shadow[slot];
          divisor = PM_HCHO_DIVISOR;
        end
      endcase
      quotient = value / divisor;
      if (quotient > Y_CLAMP) quotient = Y_CLAMP;
      r.point_valid = 1'b1;
      r.pixel_x     = 9'(X_OFFSET + int'(idx));
      r.pixel_y     = 8'(Y_BASE - quotient);
    end
    r.fill_count   = 9'(held_entries);
    r.history_full = (held_entries >= HISTORY_DEPTH);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      head_slot      = 0;
      held_entries   = 0;
      shadow_channel = CH_PM;
      shadow_wide    = 1'b0;
      error_count    = 0;
      expected_points.delete();
    end else begin
      // A result never leaves in the cycle its item is taken, so compare first.
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("result with nothing outstanding", 1, 0);
        end else begin
          want = expected_points.pop_front();
          if (point_valid !== want.point_valid)
            report_mismatch("point_valid", point_valid, want.point_valid);
          if (pixel_x !== want.pixel_x)
            report_mismatch("pixel_x", pixel_x, want.pixel_x);
          if (pixel_y !== want.pixel_y)
            report_mismatch("pixel_y", pixel_y, want.pixel_y);
          if (fill_count !== want.fill_count)
            report_mismatch("fill_count", fill_count, want.fill_count);
          if (history_full !== want.history_full)
            report_mismatch("history_full", history_full, want.history_full);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PLOT_CHANNEL: shadow_channel = cfg_data;
          REG_CO2_RANGE:    shadow_wide    = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_points.push_back(predict_plot_point(func, pm_sample, co2_sample,
                                                     hcho_sample, point_index));
      end
    end
    pending = expected_points.size();
  end

endmodule

>>> dv/trend_history_plot_buffer_top_tb.sv
// Testbench top for the trend history plot buffer: stimulus, reset, idling and verdict.
`timescale 1ns / 1ps

module trend_history_plot_buffer_top_tb;
  import thpb_pkg::*;

  // Register indexes outside the list.
  localparam logic [1:0] REG_SPARE_LOW = 2'd2;
  localparam logic [1:0] REG_SPARE_TOP = 2'd3;

  // Settling pause, in cycles, before a register write and, doubled, at the end of the run.
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int BLOCK_ITEMS   = 100;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [1:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic [15:0] pm_sample;
  logic [15:0] co2_sample;
  logic [15:0] hcho_sample;
  logic [8:0]  point_index;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        point_valid;
  logic [8:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [8:0]  fill_count;
  logic        history_full;

  int error_count;
  int pending;

  // Idling odds of the current phase, in percent per cycle.
  int send_idle_pct;
  int recv_stall_pct;

  // Rough bookkeeping on the stimulus side, only to aim reads at held entries.
  int entries_pushed;
  int pushes_done;
  int reads_done;
  int settings_done;

  trend_history_plot_buffer_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .pm_sample    (pm_sample),
    .co2_sample   (co2_sample),
    .hcho_sample  (hcho_sample),
    .point_index  (point_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .point_valid  (point_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .fill_count   (fill_count),
    .history_full (history_full)
  );

  // The checker sees every transfer on all three channels and does all of the comparing.
  trend_history_plot_buffer_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .pm_sample    (pm_sample),
    .co2_sample   (co2_sample),
    .hcho_sample  (hcho_sample),
    .point_index  (point_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .point_valid  (point_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .fill_count   (fill_count),
    .history_full (history_full),
    .error_count  (error_count),
    .pending      (pending)
  );

  // 10 ns clock, starting low.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls at the odds of the current phase. It changes only at the
  // falling edge, so the DUT sees a stable ready at every rising edge.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one item. The sender may idle first; once valid is raised it stays up with
  // the payload held until the transfer happens at a rising edge.
  task automatic issue_item(input logic f, input logic [15:0] pm, input logic [15:0] co2,
                            input logic [15:0] hcho, input logic [8:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    func        = f;
    pm_sample   = pm;
    co2_sample  = co2;
    hcho_sample = hcho;
    point_index = idx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (f == FUNC_PUSH) begin
      pushes_done++;
      if (entries_pushed < HISTORY_DEPTH) entries_pushed++;
    end else begin
      reads_done++;
    end
  endtask

  // Register writes only happen with the block idle: every result in, then a short
  // settling pause, then the write transfer.
  task automatic write_plot_reg(input logic [1:0] idx, input logic [1:0] data);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_done++;
  endtask

  // Samples are drawn up to 800, up to 6000, or anywhere in 16 bits; the first two bounds
  // lie a little above the clamp for the divisors 3 and 25.
  function automatic logic [15:0] random_sample();
    case ($urandom_range(2))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(800));
      default: return 16'($urandom_range(6000));
    endcase
  endfunction

  // A random item: half pushes, half reads. Most reads name a held position; the rest
  // pick any 9-bit index, which may land beyond the fill count.
  task automatic random_item();
    logic [8:0] idx;
    if ($urandom_range(99) < 50) begin
      issue_item(FUNC_PUSH, random_sample(), random_sample(), random_sample(),
                 9'($urandom));
    end else begin
      if (entries_pushed > 0 && $urandom_range(99) < 85)
        idx = 9'($urandom_range(entries_pushed - 1));
      else
        idx = 9'($urandom_range(511));
      issue_item(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom), idx);
    end
  endtask

  initial begin
    int drain;
    logic [1:0] pick;
    // Every input is known from time zero.
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = REG_PLOT_CHANNEL;
    cfg_data       = 2'd0;
    in_valid       = 1'b0;
    func           = FUNC_PUSH;
    pm_sample      = 16'd0;
    co2_sample     = 16'd0;
    hcho_sample    = 16'd0;
    point_index    = 9'd0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    entries_pushed = 0;
    pushes_done    = 0;
    reads_done     = 0;
    settings_done  = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with no idling on either side.
    // A read of an empty history names no held entry.
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd0);
    // Zero samples, all-ones samples, and values right at and just past the clamp.
    issue_item(FUNC_PUSH, 16'd0, 16'd0, 16'd0, 9'd0);
    issue_item(FUNC_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd511);
    issue_item(FUNC_PUSH, 16'd690, 16'd2300, 16'd693, 9'd0);
    issue_item(FUNC_PUSH, 16'd692, 16'd2301, 16'd5750, 9'd0);
    // Particulate channel after reset: every held position, the first one not held,
    // and the largest index the port can carry.
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd0);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd1);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd2);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd3);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd4);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd511);
    // CO2 with the narrow scale, then the wide one.
    write_plot_reg(REG_PLOT_CHANNEL, CH_CO2);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd1);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd2);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd3);
    write_plot_reg(REG_CO2_RANGE, 2'd1);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd1);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd3);
    // Formaldehyde.
    write_plot_reg(REG_PLOT_CHANNEL, CH_HCHO);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd2);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd3);
    // The channel code with no scale gives an empty point even for a held index.
    write_plot_reg(REG_PLOT_CHANNEL, CH_NONE);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd0);
    // Writes to indexes beyond the register list must change nothing.
    write_plot_reg(REG_SPARE_LOW, 2'd3);
    write_plot_reg(REG_SPARE_TOP, 2'd3);
    issue_item(FUNC_READ, 16'd0, 16'd0, 16'd0, 9'd1);

    // Random part: four idling phases, each split into blocks with a fresh setting.
    // With half the items pushes, the history fills and wraps more than once.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        // The undefined channel comes up now and then; bit 1 of the range data is junk.
        pick = ($urandom_range(9) == 0) ? CH_NONE : 2'($urandom_range(2));
        write_plot_reg(REG_PLOT_CHANNEL, pick);
        write_plot_reg(REG_CO2_RANGE, 2'($urandom_range(3)));
        repeat (BLOCK_ITEMS) random_item();
      end
    end

    // Let every outstanding result arrive, then a settling pause for stray transfers.
    in_valid = 1'b0;
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d pushes and %0d point reads over %0d register writes;",
             pushes_done, reads_done, settings_done);
    $display("the history wrapped %0d times, under four idling and stall mixes.",
             (pushes_done > HISTORY_DEPTH) ? (pushes_done - HISTORY_DEPTH) / HISTORY_DEPTH : 0);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (error_count == 0 && pending == 0) begin
      $display("trend_history_plot_buffer_top_tb: done, clean");
    end else begin
      $display("trend_history_plot_buffer_top_tb: done, errors");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("run timed out");
    $display("trend_history_plot_buffer_top_tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/thpb_pkg.sv
hw/rtl/trend_history_plot_buffer_top.sv
dv/trend_history_plot_buffer_checker.sv
dv/trend_history_plot_buffer_top_tb.sv
